### rtl/iusc_pkg.sv
// ----------------------------------------------------------------------------
// iusc_pkg: shared types and constants of the image upload sender
// Holds the result burst descriptor passed from the control logic to the
// output stage, the CRC-32 lookup table and parameter defaults.
// ----------------------------------------------------------------------------
package iusc_pkg;

  // Default clamp for the announced image size
  localparam int MaxImageBytesDefault = 524288;

  // Largest number of results one input transfer can cause
  localparam int BurstMax = 6;

  // Reflected CRC-32 polynomial
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  typedef logic [31:0] crc_tab_t [256];

  // Byte-wise CRC-32 table, built at elaboration
  function automatic crc_tab_t crc_gen();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CrcTab = crc_gen();

  // Results caused by one input transfer: either a run of link bytes
  // (bytes[0] first) or a single status result.
  typedef struct packed {
    logic [2:0]            count;
    logic                  is_status;
    logic [2:0]            status;
    logic [31:0]           rcrc;
    logic [BurstMax-1:0][7:0] bytes;
  } iusc_burst_t;

endpackage

### rtl/iusc_ctrl.sv
// ----------------------------------------------------------------------------
// iusc_ctrl: upload handshake control and CRC datapath
// Updates the handshake state on each accepted transfer and builds the burst
// of results that the transfer causes.
// ----------------------------------------------------------------------------
module iusc_ctrl
  import iusc_pkg::*;
#(
  parameter int MAX_IMAGE_BYTES = MaxImageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [1:0]  cmd_i,
  input  logic [19:0] image_size_i,
  input  logic [7:0]  data_byte_i,
  output iusc_burst_t burst_o
);

  // Commands
  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdData  = 2'd1;
  localparam logic [1:0] CmdRx    = 2'd2;
  localparam logic [1:0] CmdTick  = 2'd3;

  // Phases
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhWaitA  = 3'd1;
  localparam logic [2:0] PhWaitB  = 3'd2;
  localparam logic [2:0] PhStream = 3'd3;
  localparam logic [2:0] PhReply  = 3'd4;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNak      = 3'd1;
  localparam logic [2:0] StWrongAck = 3'd2;
  localparam logic [2:0] StTimeout  = 3'd3;
  localparam logic [2:0] StMismatch = 3'd4;

  // Link characters
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChN = 8'h4E;

  localparam logic [31:0] TimeoutReset = 32'd5000;
  localparam logic [31:0] MaxBytesW    = 32'(MAX_IMAGE_BYTES);

  logic [31:0] timeout_q;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] crc_q, crc_d;
  logic [19:0] bytes_left_q, bytes_left_d;
  logic [19:0] total_size_q, total_size_d;
  logic [2:0]  reply_count_q, reply_count_d;
  logic [7:0]  reply_lead_q, reply_lead_d;
  logic [31:0] reply_crc_q, reply_crc_d;
  logic [31:0] wait_cnt_q, wait_cnt_d;

  logic [19:0] size_clamp;
  logic [31:0] crc_upd, fin_upd, fin_now;
  logic [1:0]  reply_idx;
  logic [31:0] reply_crc_new;
  logic [31:0] wait_inc;

  // Size clamp, CRC step and reply assembly
  assign size_clamp    = ({12'b0, image_size_i} > MaxBytesW) ? MaxBytesW[19:0]
                                                              : image_size_i;
  assign crc_upd       = (crc_q >> 8) ^ CrcTab[crc_q[7:0] ^ data_byte_i];
  assign fin_upd       = ~crc_upd;
  assign fin_now       = ~crc_q;
  assign reply_idx     = 2'(reply_count_q - 3'd1);
  assign reply_crc_new = reply_crc_q | ({24'b0, data_byte_i} << {reply_idx, 3'b000});
  assign wait_inc      = wait_cnt_q + 32'd1;

  // Next state and result burst
  always_comb begin
    phase_d       = phase_q;
    crc_d         = crc_q;
    bytes_left_d  = bytes_left_q;
    total_size_d  = total_size_q;
    reply_count_d = reply_count_q;
    reply_lead_d  = reply_lead_q;
    reply_crc_d   = reply_crc_q;
    wait_cnt_d    = wait_cnt_q;
    burst_o       = '0;
    if (accept_i) begin
      unique case (cmd_i)
        CmdStart: begin
          total_size_d     = size_clamp;
          bytes_left_d     = size_clamp;
          crc_d            = '1;
          reply_count_d    = '0;
          reply_lead_d     = '0;
          reply_crc_d      = '0;
          wait_cnt_d       = '0;
          phase_d          = PhWaitA;
          burst_o.count    = 3'd1;
          burst_o.bytes[0] = ChR;
        end
        CmdData: begin
          if (phase_q == PhStream && bytes_left_q != '0) begin
            crc_d            = crc_upd;
            bytes_left_d     = bytes_left_q - 20'd1;
            burst_o.count    = 3'd1;
            burst_o.bytes[0] = data_byte_i;
            // last image byte: CRC packet follows
            if (bytes_left_q == 20'd1) begin
              burst_o.count    = 3'd6;
              burst_o.bytes[1] = ChC;
              burst_o.bytes[2] = fin_upd[7:0];
              burst_o.bytes[3] = fin_upd[15:8];
              burst_o.bytes[4] = fin_upd[23:16];
              burst_o.bytes[5] = fin_upd[31:24];
              phase_d          = PhReply;
              reply_count_d    = '0;
              reply_lead_d     = '0;
              reply_crc_d      = '0;
              wait_cnt_d       = '0;
            end
          end
        end
        CmdRx: begin
          unique case (phase_q)
            PhWaitA, PhWaitB: begin
              if ((phase_q == PhWaitA && data_byte_i == ChA) ||
                  (phase_q == PhWaitB && data_byte_i == ChB)) begin
                wait_cnt_d = '0;
                if (phase_q == PhWaitA) begin
                  phase_d          = PhWaitB;
                  burst_o.count    = 3'd4;
                  burst_o.bytes[0] = total_size_q[7:0];
                  burst_o.bytes[1] = total_size_q[15:8];
                  burst_o.bytes[2] = {4'b0, total_size_q[19:16]};
                  burst_o.bytes[3] = 8'h00;
                end else begin
                  phase_d = PhStream;
                  // empty image: CRC packet at once
                  if (bytes_left_q == '0) begin
                    burst_o.count    = 3'd5;
                    burst_o.bytes[0] = ChC;
                    burst_o.bytes[1] = fin_now[7:0];
                    burst_o.bytes[2] = fin_now[15:8];
                    burst_o.bytes[3] = fin_now[23:16];
                    burst_o.bytes[4] = fin_now[31:24];
                    phase_d          = PhReply;
                    reply_count_d    = '0;
                    reply_lead_d     = '0;
                    reply_crc_d      = '0;
                  end
                end
              end else begin
                phase_d           = PhIdle;
                wait_cnt_d        = '0;
                burst_o.count     = 3'd1;
                burst_o.is_status = 1'b1;
                burst_o.status    = (data_byte_i == ChN) ? StNak : StWrongAck;
              end
            end
            PhReply: begin
              if (reply_count_q == '0) begin
                reply_lead_d = data_byte_i;
              end else begin
                reply_crc_d = reply_crc_new;
              end
              reply_count_d = reply_count_q + 3'd1;
              if (reply_count_q == 3'd4) begin
                phase_d           = PhIdle;
                wait_cnt_d        = '0;
                reply_count_d     = '0;
                burst_o.count     = 3'd1;
                burst_o.is_status = 1'b1;
                burst_o.rcrc      = reply_crc_new;
                burst_o.status    = (reply_lead_q == ChC && reply_crc_new == fin_now)
                                    ? StOk : StMismatch;
              end
            end
            default: begin
            end
          endcase
        end
        CmdTick: begin
          if (phase_q == PhWaitA || phase_q == PhWaitB || phase_q == PhReply) begin
            wait_cnt_d = wait_inc;
            if (wait_inc >= timeout_q) begin
              phase_d           = PhIdle;
              wait_cnt_d        = '0;
              burst_o.count     = 3'd1;
              burst_o.is_status = 1'b1;
              burst_o.status    = StTimeout;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TimeoutReset;
      phase_q       <= PhIdle;
      crc_q         <= '1;
      bytes_left_q  <= '0;
      total_size_q  <= '0;
      reply_count_q <= '0;
      reply_lead_q  <= '0;
      reply_crc_q   <= '0;
      wait_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      phase_q       <= phase_d;
      crc_q         <= crc_d;
      bytes_left_q  <= bytes_left_d;
      total_size_q  <= total_size_d;
      reply_count_q <= reply_count_d;
      reply_lead_q  <= reply_lead_d;
      reply_crc_q   <= reply_crc_d;
      wait_cnt_q    <= wait_cnt_d;
    end
  end

endmodule

### rtl/iusc_burst.sv
// ----------------------------------------------------------------------------
// iusc_burst: result output stage
// Holds the burst of one input transfer and hands it out one result per
// transfer on the master side, marking the final one with tlast.
// ----------------------------------------------------------------------------
module iusc_burst
  import iusc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  iusc_burst_t burst_i,
  output logic        load_ok_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [2:0]                cnt_q, cnt_d;
  logic                      is_status_q;
  logic [2:0]                status_q;
  logic [31:0]               rcrc_q;
  logic [BurstMax-1:0][7:0]  bytes_q, bytes_d;
  logic                      take;

  assign take      = m_axis_tvalid && m_axis_tready;
  // a new burst may enter once the held one is gone or leaves now
  assign load_ok_o = (cnt_q == '0) || (cnt_q == 3'd1 && m_axis_tready);

  // Count and byte shift line
  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (load_i) begin
      cnt_d   = burst_i.count;
      bytes_d = burst_i.bytes;
    end else if (take) begin
      cnt_d = cnt_q - 3'd1;
      for (int i = 0; i < BurstMax - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    if (load_i) begin
      is_status_q <= burst_i.is_status;
      status_q    <= burst_i.status;
      rcrc_q      <= burst_i.rcrc;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = (cnt_q == 3'd1);
  assign m_axis_tuser  = is_status_q;
  assign m_axis_tdata  = {5'b0, rcrc_q, status_q, bytes_q[0]};

endmodule

### rtl/image_upload_sender_with_crc_unit.sv
// ----------------------------------------------------------------------------
// image_upload_sender_with_crc_unit: image upload sender with CRC-32 check
// The first result of an input transfer is valid in the cycle after it.
// Throughput: one input transfer per cycle while each causes at most one
// result (or none) and the output is ready; a transfer causing more holds
// the input until the single-result output stage has sent all but its last.
// Reset: asynchronous, active low; idle phase, timeout 5000, no result held.
// ----------------------------------------------------------------------------
module image_upload_sender_with_crc_unit
  import iusc_pkg::*;
#(
  parameter int MAX_IMAGE_BYTES = MaxImageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: timeout_ticks
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // image_size[19:0], data_byte[27:20], zero
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // tx_byte[7:0], status[10:8], remote_crc[42:11]
  output logic        m_axis_tuser,  // kind[0]
  output logic        m_axis_tlast
);

  iusc_burst_t burst;
  logic        load_ok;
  logic        accept;

  assign s_axis_tready = load_ok;
  assign accept        = s_axis_tvalid && load_ok;

  iusc_ctrl #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser),
    .image_size_i(s_axis_tdata[19:0]),
    .data_byte_i (s_axis_tdata[27:20]),
    .burst_o     (burst)
  );

  iusc_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .burst_i      (burst),
    .load_ok_o    (load_ok),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
